FILE: rtl/rrsm_pkg.sv
`default_nettype none
package rrsm_pkg;

    // Width of the endpoint values on the input ports
    localparam int VAL_W = 32;

    // Endpoint kinds as coded on start_kind / end_kind
    localparam logic [1:0] KIND_INT  = 2'd0;
    localparam logic [1:0] KIND_FRAC = 2'd1;
    localparam logic [1:0] KIND_EDGE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_APPENDED = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_MERGED   = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    // Command codes
    localparam logic CMD_APPEND  = 1'b0;
    localparam logic CMD_RESOLVE = 1'b1;

    // Stored raw endpoint: integer position or fraction in 0..1.0
    typedef struct packed {
        logic                    frac;
        logic signed [VAL_W-1:0] value;
    } ep_t;

endpackage
`default_nettype wire

FILE: rtl/range_resolve_sort_merge_top.sv
`default_nettype none
// Channel   | Handshake             | Ports
// ----------+-----------------------+-----------------------------------------------
// command   | start & !busy         | command, start_kind, start_value, end_kind,
//           |                       | end_value, seq_length
// result    | valid (one cycle)     | status, range_start, range_end, last
//
// An append answers in the cycle after acceptance; busy stays low.
// A resolve places the endpoints of each raw range in turn (S_RD, S_MS, S_CS,
// S_CE), then runs a selection pass over the M surviving ranges for each of them
// (one resolved-table read per cycle through the shared compare), then a merge.
// Reset restores the single default full range; no clearing pass is needed.
// Results cannot be stalled: each is shown for exactly one cycle.
module range_resolve_sort_merge_top
    import rrsm_pkg::*;
#(
    parameter int MAX_RANGES = 16,
    parameter int LEN_BITS   = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              command,
    input  wire logic [1:0]        start_kind,
    input  wire logic signed [31:0] start_value,
    input  wire logic [1:0]        end_kind,
    input  wire logic signed [31:0] end_value,
    input  wire logic [31:0]       seq_length,
    output logic                   valid,
    output logic [1:0]             status,
    output logic [31:0]            range_start,
    output logic [31:0]            range_end,
    output logic                   last
);

    localparam int LW = (LEN_BITS < 32) ? LEN_BITS : 32;
    localparam int IW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam logic signed [VAL_W-1:0] ONE_FX = VAL_W'(1) <<< FRAC_BITS;
    localparam ep_t DEF_START = '{frac: 1'b0, value: VAL_W'(1)};
    localparam ep_t DEF_END   = '{frac: 1'b0, value: -VAL_W'(1)};

    typedef struct packed {
        logic ok;
        ep_t  ep;
    } dec_t;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_MS, S_CS, S_CE, S_SCAN, S_MRG, S_FIN
    } state_t;

    function automatic dec_t decode(input logic [1:0] kind,
                                    input logic signed [VAL_W-1:0] raw,
                                    input logic signed [VAL_W-1:0] edge_v);
        dec_t d;
        d.ok       = 1'b0;
        d.ep.frac  = 1'b0;
        d.ep.value = raw;
        unique case (kind)
            KIND_EDGE:
            begin
                d.ok       = 1'b1;
                d.ep.value = edge_v;
            end
            KIND_INT:
            begin
                d.ok = (raw != 0);
            end
            KIND_FRAC:
            begin
                d.ep.frac = 1'b1;
                d.ok      = (raw >= -ONE_FX) && (raw <= ONE_FX);
                if (raw < 0)
                begin
                    d.ep.value = raw + ONE_FX;
                end
            end
            default:
            begin
                d.ok = 1'b0;
            end
        endcase
        return d;
    endfunction

    // Raw range table and resolved table (no reset: read only below the count)
    ep_t            raw_s_mem [MAX_RANGES];
    ep_t            raw_e_mem [MAX_RANGES];
    logic [LW-1:0]  res_s_mem [MAX_RANGES];
    logic [LW-1:0]  res_e_mem [MAX_RANGES];
    ep_t            raw_s_rd_reg, raw_e_rd_reg;
    logic [LW-1:0]  res_s_rd_reg, res_e_rd_reg;

    state_t             state_reg, state_next;
    logic [CW-1:0]      raw_count_reg, raw_count_next;
    logic               dflt_reg, dflt_next;
    logic [LW-1:0]      len_reg, len_next;
    logic [CW-1:0]      i_reg, i_next;
    logic [CW-1:0]      nres_reg, nres_next;
    logic [LW-1:0]      a_reg, a_next;
    logic [MAX_RANGES-1:0] used_reg, used_next;
    logic [CW-1:0]      sc_reg, sc_next;
    logic               ev_vld_reg, ev_vld_next;
    logic [IW-1:0]      ev_idx_reg, ev_idx_next;
    logic               bf_reg, bf_next;
    logic [IW-1:0]      bi_reg, bi_next;
    logic [LW-1:0]      bs_reg, bs_next, be_reg, be_next;
    logic               hc_reg, hc_next;
    logic [LW-1:0]      cs_reg, cs_next, ce_reg, ce_next;
    logic [CW-1:0]      pass_reg, pass_next;
    logic               valid_reg, valid_next;
    logic [1:0]         status_reg, status_next;
    logic [LW-1:0]      rs_reg, rs_next, re_reg, re_next;
    logic               last_reg, last_next;

    dec_t               ds, de;
    logic               app_ok;
    logic [CW-1:0]      eff_count;
    logic               raw_we;
    logic               res_we;
    ep_t                ep_in;
    logic [LW-1:0]      pos;
    logic [CW-1:0]      n_raw;

    // Append checks
    always_comb
    begin
        ds        = decode(start_kind, start_value, VAL_W'(1));
        de        = decode(end_kind, end_value, -VAL_W'(1));
        eff_count = dflt_reg ? '0 : raw_count_reg;
        app_ok    = (eff_count < CW'(MAX_RANGES)) && ds.ok && de.ok;
        if (ds.ep.frac && de.ep.frac && (ds.ep.value > de.ep.value))
        begin
            app_ok = 1'b0;
        end
        if (!ds.ep.frac && !de.ep.frac &&
            ((ds.ep.value < 0) == (de.ep.value < 0)) &&
            (ds.ep.value > de.ep.value))
        begin
            app_ok = 1'b0;
        end
        raw_we = (state_reg == S_IDLE) && start && (command == CMD_APPEND) && app_ok;
    end

    // Raw table
    always_ff @(posedge clk)
    begin
        if (raw_we)
        begin
            raw_s_mem[eff_count[IW-1:0]] <= ds.ep;
            raw_e_mem[eff_count[IW-1:0]] <= de.ep;
        end
        raw_s_rd_reg <= raw_s_mem[i_reg[IW-1:0]];
        raw_e_rd_reg <= raw_e_mem[i_reg[IW-1:0]];
    end

    // Shared placement unit
    assign ep_in = (state_reg == S_MS)
                 ? (dflt_reg ? DEF_START : raw_s_rd_reg)
                 : (dflt_reg ? DEF_END : raw_e_rd_reg);

    rrsm_place #(
        .LW        (LW),
        .FRAC_BITS (FRAC_BITS)
    ) u_place (
        .clk (clk),
        .ep  (ep_in),
        .len (len_reg),
        .pos (pos)
    );

    assign res_we = (state_reg == S_CE) && (pos >= a_reg);

    // Resolved table
    always_ff @(posedge clk)
    begin
        if (res_we)
        begin
            res_s_mem[nres_reg[IW-1:0]] <= a_reg;
            res_e_mem[nres_reg[IW-1:0]] <= pos;
        end
        res_s_rd_reg <= res_s_mem[sc_reg[IW-1:0]];
        res_e_rd_reg <= res_e_mem[sc_reg[IW-1:0]];
    end

    assign n_raw = dflt_reg ? CW'(1) : raw_count_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        raw_count_next = raw_count_reg;
        dflt_next      = dflt_reg;
        len_next       = len_reg;
        i_next         = i_reg;
        nres_next      = nres_reg;
        a_next         = a_reg;
        used_next      = used_reg;
        sc_next        = sc_reg;
        ev_vld_next    = 1'b0;
        ev_idx_next    = ev_idx_reg;
        bf_next        = bf_reg;
        bi_next        = bi_reg;
        bs_next        = bs_reg;
        be_next        = be_reg;
        hc_next        = hc_reg;
        cs_next        = cs_reg;
        ce_next        = ce_reg;
        pass_next      = pass_reg;
        valid_next     = 1'b0;
        status_next    = status_reg;
        rs_next        = '0;
        re_next        = '0;
        last_next      = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (command == CMD_APPEND)
                    begin
                        dflt_next      = 1'b0;
                        raw_count_next = eff_count + CW'(app_ok);
                        valid_next     = 1'b1;
                        status_next    = app_ok ? ST_APPENDED : ST_REJECTED;
                    end
                    // zero length or an empty raw table: nothing to resolve
                    else if ((seq_length[LW-1:0] == '0) || (n_raw == '0))
                    begin
                        valid_next  = 1'b1;
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        len_next   = seq_length[LW-1:0];
                        i_next     = '0;
                        nres_next  = '0;
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_MS;
            end
            S_MS:
            begin
                state_next = S_CS;
            end
            S_CS:
            begin
                a_next     = pos;
                state_next = S_CE;
            end
            S_CE:
            begin
                nres_next = nres_reg + CW'(res_we);
                i_next    = i_reg + CW'(1);
                if (i_reg + CW'(1) == n_raw)
                begin
                    if (nres_next == '0)
                    begin
                        valid_next  = 1'b1;
                        status_next = ST_EMPTY;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        used_next  = '0;
                        sc_next    = '0;
                        bf_next    = 1'b0;
                        hc_next    = 1'b0;
                        pass_next  = '0;
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_SCAN:
            begin
                // issue one read per cycle
                if (sc_reg < nres_reg)
                begin
                    ev_vld_next = 1'b1;
                    ev_idx_next = sc_reg[IW-1:0];
                    sc_next     = sc_reg + CW'(1);
                end
                // compare the entry read last cycle against the best so far
                if (ev_vld_reg)
                begin
                    if (!used_reg[ev_idx_reg] && (!bf_reg || (res_s_rd_reg < bs_reg)))
                    begin
                        bf_next = 1'b1;
                        bi_next = ev_idx_reg;
                        bs_next = res_s_rd_reg;
                        be_next = res_e_rd_reg;
                    end
                    if (CW'(ev_idx_reg) == nres_reg - CW'(1))
                    begin
                        state_next = S_MRG;
                    end
                end
            end
            S_MRG:
            begin
                used_next[bi_reg] = 1'b1;
                if (!hc_reg)
                begin
                    hc_next = 1'b1;
                    cs_next = bs_reg;
                    ce_next = be_reg;
                end
                else if ((CW'(0) + {1'b0, ce_reg}) + (LW+1)'(1) < {1'b0, bs_reg})
                begin
                    valid_next  = 1'b1;
                    status_next = ST_MERGED;
                    rs_next     = cs_reg;
                    re_next     = ce_reg;
                    last_next   = 1'b0;
                    cs_next     = bs_reg;
                    ce_next     = be_reg;
                end
                else if (be_reg > ce_reg)
                begin
                    ce_next = be_reg;
                end
                pass_next = pass_reg + CW'(1);
                if (pass_reg + CW'(1) == nres_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    sc_next    = '0;
                    bf_next    = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_FIN:
            begin
                valid_next  = 1'b1;
                status_next = ST_MERGED;
                rs_next     = cs_reg;
                re_next     = ce_reg;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            raw_count_reg <= CW'(1);
            dflt_reg      <= 1'b1;
            valid_reg     <= 1'b0;
            ev_vld_reg    <= 1'b0;
            used_reg      <= '0;
            hc_reg        <= 1'b0;
            bf_reg        <= 1'b0;
            i_reg         <= '0;
            nres_reg      <= '0;
            sc_reg        <= '0;
            pass_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            raw_count_reg <= raw_count_next;
            dflt_reg      <= dflt_next;
            valid_reg     <= valid_next;
            ev_vld_reg    <= ev_vld_next;
            used_reg      <= used_next;
            hc_reg        <= hc_next;
            bf_reg        <= bf_next;
            i_reg         <= i_next;
            nres_reg      <= nres_next;
            sc_reg        <= sc_next;
            pass_reg      <= pass_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        len_reg    <= len_next;
        a_reg      <= a_next;
        ev_idx_reg <= ev_idx_next;
        bi_reg     <= bi_next;
        bs_reg     <= bs_next;
        be_reg     <= be_next;
        cs_reg     <= cs_next;
        ce_reg     <= ce_next;
        status_reg <= status_next;
        rs_reg     <= rs_next;
        re_reg     <= re_next;
        last_reg   <= last_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign valid       = valid_reg;
    assign status      = status_reg;
    assign range_start = 32'(rs_reg);
    assign range_end   = 32'(re_reg);
    assign last        = last_reg;

    // An append answers in the next cycle with a single result
    a_append_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == CMD_APPEND)) |=> (valid && last))
        else $error("append did not answer in one cycle");

    // Merged ranges are never empty
    a_merged_order: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && (status == ST_MERGED)) |-> (range_start <= range_end))
        else $error("merged range with start after end");

    // Resolved count never exceeds the table
    a_nres_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nres_reg <= CW'(MAX_RANGES))
        else $error("resolved count overflow");

    // Only merged ranges may be followed by more results
    a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && (status != ST_MERGED)) |-> last)
        else $error("non-range result without last");

endmodule
`default_nettype wire

FILE: rtl/rrsm_place.sv
`default_nettype none
// Endpoint placement unit: multiply register, then map and clamp to 1..len.
// Result is valid in the cycle after ep is presented (one register inside).
module rrsm_place
    import rrsm_pkg::*;
#(
    parameter int LW        = 32,
    parameter int FRAC_BITS = 16
)
(
    input  wire logic          clk,
    input  wire ep_t           ep,
    input  wire logic [LW-1:0] len,
    output logic      [LW-1:0] pos
);

    localparam int PW = LW + FRAC_BITS + 1;
    localparam int RW = VAL_W + 2;

    logic [PW-1:0]        prod_reg;
    ep_t                  ep_reg;
    logic signed [RW-1:0] r;
    logic signed [RW-1:0] len_s;

    // (len - 1) * fraction, registered
    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(len - LW'(1)) * PW'(ep.value[FRAC_BITS:0]);
        ep_reg   <= ep;
    end

    // Map to a position, then clamp
    always_comb
    begin
        len_s = signed'(RW'(len));
        if (ep_reg.frac)
        begin
            r = signed'(RW'(prod_reg[PW-1:FRAC_BITS])) + RW'(1);
        end
        else if (ep_reg.value < 0)
        begin
            r = len_s + RW'(1) + RW'(signed'(ep_reg.value));
        end
        else
        begin
            r = RW'(signed'(ep_reg.value));
        end
        if (r < RW'(1))
        begin
            pos = LW'(1);
        end
        else if (r > len_s)
        begin
            pos = len;
        end
        else
        begin
            pos = r[LW-1:0];
        end
    end

endmodule
`default_nettype wire
